>>> rtl/core/carr_pkg.sv
// Shared types, constants and CORDIC step functions for the chroma angle remap block.
package carr_pkg;

   localparam int DATA_W  = 16;
   localparam int XW      = 24;   // chroma datapath: 4 guard bits plus CORDIC growth
   localparam int ZW      = 34;   // angle datapath, pi = 2^31
   localparam int TAB_LEN = 30;
   localparam int GAIN_SHIFT = 28;
   localparam int PW      = XW + 25;

   localparam logic signed [ZW-1:0] ANG_PI2 = 34'sd1073741824;
   localparam logic signed [ZW-1:0] ANG_PI  = 34'sd2147483648;
   localparam logic signed [ZW-1:0] ANG_PI3 = 34'sd715827883;
   localparam logic signed [24:0]   RECIP_GAIN2 = 25'sd6186701;
   localparam logic [31:0]          DIV3_RECIP  = 32'hAAAAAAAB;

   localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

   localparam logic FUNC_FORWARD = 1'b0;
   localparam logic FUNC_INVERSE = 1'b1;

   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] luma;
      logic signed [DATA_W-1:0] chan_a;
      logic signed [DATA_W-1:0] chan_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] luma_out;
      logic signed [DATA_W-1:0] chan_a_out;
      logic signed [DATA_W-1:0] chan_b_out;
      logic                     clipped;
   } rsp_type;

   typedef struct packed {
      logic                     func;
      logic                     neg;
      logic signed [DATA_W-1:0] luma;
      logic signed [XW-1:0]     x;
      logic signed [XW-1:0]     y;
      logic signed [ZW-1:0]     z;
   } work_type;

   function automatic logic signed [ZW-1:0] atan_val(input int i);
      return $signed({{(ZW-32){1'b0}}, ATAN_TAB[i]});
   endfunction

   // vectoring step: drive y toward zero
   function automatic work_type vec_step(input work_type w, input int i);
      work_type r;
      r = w;
      if (!w.y[XW-1]) begin
         r.x = w.x + (w.y >>> i);
         r.y = w.y - (w.x >>> i);
         r.z = w.z + atan_val(i);
      end else begin
         r.x = w.x - (w.y >>> i);
         r.y = w.y + (w.x >>> i);
         r.z = w.z - atan_val(i);
      end
      return r;
   endfunction

   // rotation step: drive z toward zero
   function automatic work_type rot_step(input work_type w, input int i);
      work_type r;
      r = w;
      if (!w.z[ZW-1]) begin
         r.x = w.x - (w.y >>> i);
         r.y = w.y + (w.x >>> i);
         r.z = w.z - atan_val(i);
      end else begin
         r.x = w.x + (w.y >>> i);
         r.y = w.y - (w.x >>> i);
         r.z = w.z + atan_val(i);
      end
      return r;
   endfunction

endpackage

>>> rtl/core/chroma_angle_remap_rotation.sv
// Chroma angle remap: one pixel per clock while results are popped, fully pipelined. A pixel
// goes through an input register, a two-entry queue, a back-end entry register,
// ANGLE_STAGES vectoring steps, three remap stages, ANGLE_STAGES rotation steps, a gain
// multiply and a saturating output register; every back-end stage holds while the output
// register is full and not popped.
module chroma_angle_remap_rotation #(
   parameter int ANGLE_STAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  carr_pkg::req_type req_data,
   output logic              req_full,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output carr_pkg::rsp_type rsp_data
);
   import carr_pkg::*;

   logic     q_push, q_full, q_empty, q_pop, back_ready;
   work_type q_in, q_out;

   assign q_pop = !q_empty && back_ready;

   carr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   carr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   carr_back #(
      .STAGES (ANGLE_STAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_data   (q_out),
      .in_ready  (back_ready),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("queue read while empty");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty) else $error("result pending after reset");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("unpopped result changed");
`endif

endmodule

>>> rtl/core/carr_front.sv
// Front end: takes pixels, folds the chroma vector into the right half plane.
module carr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  carr_pkg::req_type req_data,
   output logic              req_full,
   input  logic              q_full,
   output logic              q_push,
   output carr_pkg::work_type q_data
);
   import carr_pkg::*;

   logic              valid_ff, valid_in;
   work_type          data_ff, data_in;
   logic signed [DATA_W:0] b_mag;
   logic signed [XW-1:0]   xs, ys;
   logic              take;

   assign q_push   = valid_ff && !q_full;
   assign req_full = valid_ff && q_full;
   assign take     = req_push && !req_full;
   assign q_data   = data_ff;

   always_comb begin
      b_mag = req_data.chan_b[DATA_W-1] ?
              -$signed({req_data.chan_b[DATA_W-1], req_data.chan_b}) :
              $signed({req_data.chan_b[DATA_W-1], req_data.chan_b});
      xs = $signed({{(XW-DATA_W){req_data.chan_a[DATA_W-1]}}, req_data.chan_a}) <<< 4;
      ys = $signed({{(XW-DATA_W-1){b_mag[DATA_W]}}, b_mag}) <<< 4;
      data_in.func = req_data.func;
      data_in.neg  = req_data.chan_b[DATA_W-1];
      data_in.luma = req_data.luma;
      if (xs[XW-1]) begin
         // left half plane: pre-rotate by -90 degrees
         data_in.x = ys;
         data_in.y = -xs;
         data_in.z = ANG_PI2;
      end else begin
         data_in.x = xs;
         data_in.y = ys;
         data_in.z = '0;
      end
      valid_in = take || (valid_ff && !q_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/core/carr_queue.sv
// Two-entry queue between the front end and the CORDIC back end.
module carr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  carr_pkg::work_type push_data,
   input  logic               pop,
   output carr_pkg::work_type pop_data,
   output logic               full,
   output logic               empty
);
   import carr_pkg::*;

   work_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/carr_back.sv
// Back end: vectoring CORDIC, angle remap, rotation CORDIC, gain and saturation.
module carr_back #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  carr_pkg::work_type in_data,
   output logic               in_ready,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output carr_pkg::rsp_type  rsp_data
);
   import carr_pkg::*;

   typedef struct packed {
      logic                     neg;
      logic signed [DATA_W-1:0] luma;
      logic signed [PW-1:0]     px;
      logic signed [PW-1:0]     py;
   } gain_type;

   localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (GAIN_SHIFT - 1);
   localparam logic signed [PW-1:0] SAT_HI = PW'((1 << (DATA_W - 1)) - 1);
   localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

   logic     adv;
   work_type vec_ff [STAGES+1];
   logic     vec_v_ff [STAGES+1];
   work_type rot_ff [STAGES+1];
   logic     rot_v_ff [STAGES+1];
   work_type r1_ff, r1_in, r2_ff, r2_in;
   logic     r1_v_ff, r2_v_ff;
   logic [31:0] q2_ff, q2_in;
   logic [31:0] u;
   logic [63:0] prod;
   work_type    r3_in;
   logic signed [ZW-1:0] t_new;
   gain_type g_ff, g_in;
   logic     g_v_ff;
   rsp_type  out_ff, out_in;
   logic     out_v_ff;
   logic signed [PW-1:0] rx, ry;
   logic     clip_x, clip_y;

   assign adv       = !out_v_ff || rsp_pop;
   assign in_ready  = adv;
   assign rsp_empty = !out_v_ff;
   assign rsp_data  = out_ff;

   // clamp the vectoring angle to [0, pi]
   always_comb begin
      r1_in = vec_ff[STAGES];
      if (vec_ff[STAGES].z[ZW-1]) begin
         r1_in.z = '0;
      end else if (vec_ff[STAGES].z > ANG_PI) begin
         r1_in.z = ANG_PI;
      end
   end

   // one-third via reciprocal multiply, shared by both inverse segments
   always_comb begin
      r2_in = r1_ff;
      if (r1_ff.z < ANG_PI2) begin
         u = r1_ff.z[30:0] << 1;
      end else begin
         u = 32'(r1_ff.z - ANG_PI2);
      end
      prod  = u * DIV3_RECIP;
      q2_in = {1'b0, prod[63:33]};
   end

   // finish the remap and fold large angles into the rotation range
   always_comb begin
      if (r2_ff.func == FUNC_FORWARD) begin
         if (r2_ff.z < ANG_PI3) begin
            t_new = r2_ff.z + (r2_ff.z >>> 1);
         end else begin
            t_new = ANG_PI2 + (((r2_ff.z - ANG_PI3) * 3) >>> 2);
         end
      end else begin
         if (r2_ff.z < ANG_PI2) begin
            t_new = $signed({{(ZW-32){1'b0}}, q2_ff});
         end else begin
            t_new = ANG_PI3 + (r2_ff.z - ANG_PI2) + $signed({{(ZW-32){1'b0}}, q2_ff});
         end
      end
      r3_in = r2_ff;
      if (t_new > ANG_PI2) begin
         r3_in.x = '0;
         r3_in.y = r2_ff.x;
         r3_in.z = t_new - ANG_PI2;
      end else begin
         r3_in.y = '0;
         r3_in.z = t_new;
      end
   end

   always_comb begin
      g_in.neg  = rot_ff[STAGES].neg;
      g_in.luma = rot_ff[STAGES].luma;
      g_in.px   = PW'(rot_ff[STAGES].x) * PW'(RECIP_GAIN2);
      g_in.py   = PW'(rot_ff[STAGES].y) * PW'(RECIP_GAIN2);
   end

   always_comb begin
      rx = (g_ff.px + ROUND_HALF) >>> GAIN_SHIFT;
      ry = (g_ff.py + ROUND_HALF) >>> GAIN_SHIFT;
      if (g_ff.neg) begin
         ry = -ry;
      end
      clip_x = (rx > SAT_HI) || (rx < SAT_LO);
      clip_y = (ry > SAT_HI) || (ry < SAT_LO);
      out_in.luma_out   = g_ff.luma;
      out_in.chan_a_out = (rx > SAT_HI) ? SAT_HI[DATA_W-1:0] :
                          (rx < SAT_LO) ? SAT_LO[DATA_W-1:0] : rx[DATA_W-1:0];
      out_in.chan_b_out = (ry > SAT_HI) ? SAT_HI[DATA_W-1:0] :
                          (ry < SAT_LO) ? SAT_LO[DATA_W-1:0] : ry[DATA_W-1:0];
      out_in.clipped    = clip_x || clip_y;
   end

   genvar i;
   generate
      for (i = 0; i < STAGES; i++) begin : g_iter
         always_ff @(posedge clock) begin
            if (reset) begin
               vec_v_ff[i+1] <= 1'b0;
               rot_v_ff[i+1] <= 1'b0;
            end else if (adv) begin
               vec_v_ff[i+1] <= vec_v_ff[i];
               rot_v_ff[i+1] <= rot_v_ff[i];
            end
            if (adv) begin
               vec_ff[i+1] <= vec_step(vec_ff[i], i);
               rot_ff[i+1] <= rot_step(rot_ff[i], i);
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_v_ff[0] <= 1'b0;
         r1_v_ff     <= 1'b0;
         r2_v_ff     <= 1'b0;
         rot_v_ff[0] <= 1'b0;
         g_v_ff      <= 1'b0;
         out_v_ff    <= 1'b0;
      end else if (adv) begin
         vec_v_ff[0] <= in_valid;
         r1_v_ff     <= vec_v_ff[STAGES];
         r2_v_ff     <= r1_v_ff;
         rot_v_ff[0] <= r2_v_ff;
         g_v_ff      <= rot_v_ff[STAGES];
         out_v_ff    <= g_v_ff;
      end
      if (adv) begin
         vec_ff[0] <= in_data;
         r1_ff     <= r1_in;
         r2_ff     <= r2_in;
         q2_ff     <= q2_in;
         rot_ff[0] <= r3_in;
         g_ff      <= g_in;
         out_ff    <= out_in;
      end
   end

endmodule

>>> verif/carr_checker.sv
// Checker for the chroma angle remap block: predicts each pixel and compares results.
`timescale 1ns / 1ps
module carr_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  carr_pkg::req_type req_data,
   input  logic              rsp_pop,
   input  logic              rsp_empty,
   input  carr_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import carr_pkg::*;

   localparam int STAGES = 16;

   rsp_type pixel_q[$];

   function automatic longint shr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint atan_at(input int i);
      return longint'({32'd0, ATAN_TAB[i]});
   endfunction

   function automatic longint clamp_sample(input longint v, inout logic clip);
      if (v > 32767) begin
         clip = 1'b1;
         return 32767;
      end
      if (v < -32768) begin
         clip = 1'b1;
         return -32768;
      end
      return v;
   endfunction

   function automatic rsp_type remap_pixel(input req_type p);
      rsp_type r;
      longint x, y, z, nx, ny, t, b;
      logic neg, clip;
      neg = p.chan_b < 0;
      b = p.chan_b;
      if (neg) b = -b;
      x = longint'(p.chan_a) * 16;
      y = b * 16;
      z = 0;
      clip = 1'b0;
      if (x < 0) begin
         nx = y;
         y = -x;
         x = nx;
         z = ANG_PI2;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (y >= 0) begin
            nx = x + shr(y, i);
            ny = y - shr(x, i);
            z += atan_at(i);
         end else begin
            nx = x - shr(y, i);
            ny = y + shr(x, i);
            z -= atan_at(i);
         end
         x = nx;
         y = ny;
      end
      if (z < 0) z = 0;
      if (z > ANG_PI) z = ANG_PI;
      // angle is nonnegative here, so C truncating division equals floor
      if (p.func == FUNC_FORWARD)
         t = (z < ANG_PI3) ? z + z / 2 : ANG_PI2 + ((z - ANG_PI3) * 3) / 4;
      else
         t = (z < ANG_PI2) ? (z * 2) / 3 : ANG_PI3 + ((z - ANG_PI2) * 4) / 3;
      y = 0;
      z = t;
      if (t > ANG_PI2) begin
         y = x;
         x = 0;
         z = t - ANG_PI2;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = x - shr(y, i);
            ny = y + shr(x, i);
            z -= atan_at(i);
         end else begin
            nx = x + shr(y, i);
            ny = y - shr(x, i);
            z += atan_at(i);
         end
         x = nx;
         y = ny;
      end
      x = shr(x * 6186701 + (64'sd1 <<< 27), 28);
      y = shr(y * 6186701 + (64'sd1 <<< 27), 28);
      if (neg) y = -y;
      x = clamp_sample(x, clip);
      y = clamp_sample(y, clip);
      r.luma_out = p.luma;
      r.chan_a_out = x[15:0];
      r.chan_b_out = y[15:0];
      r.clipped = clip;
      return r;
   endfunction

   assign pending_count = pixel_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pixel_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pixel_q.size() == 0) begin
               $error("unexpected result transfer: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_data !== want) begin
                  if (rsp_data.luma_out !== want.luma_out)
                     $error("luma_out: expected %0d, got %0d", want.luma_out, rsp_data.luma_out);
                  if (rsp_data.chan_a_out !== want.chan_a_out)
                     $error("chan_a_out: expected %0d, got %0d",
                            want.chan_a_out, rsp_data.chan_a_out);
                  if (rsp_data.chan_b_out !== want.chan_b_out)
                     $error("chan_b_out: expected %0d, got %0d",
                            want.chan_b_out, rsp_data.chan_b_out);
                  if (rsp_data.clipped !== want.clipped)
                     $error("clipped: expected %0b, got %0b", want.clipped, rsp_data.clipped);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_push && !req_full)
            pixel_q.push_back(remap_pixel(req_data));
      end
   end
endmodule

>>> verif/tb_top.sv
// Testbench top: drives pixels and result pops, and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
   import carr_pkg::*;

   localparam int LATENCY = 2 * 16 + 8;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_pop = 1'b0;
   logic    rsp_empty;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;

   always #4 clock = ~clock;

   chroma_angle_remap_rotation uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data)
   );

   carr_checker checker_i (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** chroma_angle_remap_rotation: FAILED **");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_pop <= !reset && ($urandom_range(99) >= stall_pct);

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(5))
         0: return 16'sh7FFF - $signed(16'($urandom_range(3)));
         1: return 16'sh8000 + $signed(16'($urandom_range(3)));
         2: return $signed(16'($urandom_range(15))) - 16'sd8;
         default: return $signed(16'($urandom));
      endcase
   endfunction

   // one transfer; sender gaps only between pixels
   task automatic send_pixel(input req_type p);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   initial begin
      req_type p;
      int edge_vals[6];
      edge_vals = '{32767, -32768, 0, 1, -1, 16384};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: full-scale, on-axis and small chroma values, both modes
      for (int f = 0; f < 2; f++)
         for (int k = 0; k < 12; k++) begin
            p.func = f[0];
            p.luma = (k & 1) ? 16'sh8000 : 16'sh7FFF;
            p.chan_a = 16'(edge_vals[k % 6]);
            p.chan_b = 16'(edge_vals[(k * 5 + 2) % 6]);
            send_pixel(p);
         end
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 53 : 33) : 0;
         stall_pct = (ph == 2) ? 53 : ((ph == 3) ? 33 : 0);
         for (int n = 0; n < 400; n++) begin
            p.func = 1'($urandom_range(1));
            p.luma = $signed(16'($urandom));
            p.chan_a = rand_sample();
            p.chan_b = rand_sample();
            send_pixel(p);
         end
      end
      req_push <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (fail_count == 0)
         $display("** chroma_angle_remap_rotation: PASSED **");
      else
         $display("** chroma_angle_remap_rotation: FAILED **");
      $finish;
   end
endmodule

>>> filelist.f
rtl/core/carr_pkg.sv
rtl/core/carr_front.sv
rtl/core/carr_queue.sv
rtl/core/carr_back.sv
rtl/core/chroma_angle_remap_rotation.sv
verif/carr_checker.sv
verif/tb_top.sv
